### rtl/binary_to_decimal_ascii_defines.svh
// ============================================================================
// Assertion macros for binary_to_decimal_ascii
// Shared concurrent assertion forms used by the port checker.
// ============================================================================
`ifndef BINARY_TO_DECIMAL_ASCII_DEFINES_SVH
`define BINARY_TO_DECIMAL_ASCII_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BDASC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("binary_to_decimal_ascii: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define BDASC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("binary_to_decimal_ascii: next-cycle check failed");

`endif

### rtl/bdasc_pkg.sv
// ============================================================================
// bdasc_pkg
// Types and constants shared by the binary to decimal ASCII converter.
// ============================================================================
`default_nettype none

package bdasc_pkg;

    // Input value width and the decimal digits it can produce.
    localparam int VALUE_WIDTH = 64;
    localparam int MAX_DIGITS  = 20;

    localparam int BIT_CNT_W   = $clog2(VALUE_WIDTH);
    localparam int DIGIT_IDX_W = $clog2(MAX_DIGITS);
    localparam int COUNT_W     = 5;
    localparam int CHAR_W      = 6;
    localparam int BCD_W       = 4;

    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 16;

    localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic shift;
        logic count;
        logic emit;
    } bdasc_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic bit_last;
        logic pos_zero;
        logic out_free;
    } bdasc_status_t;

endpackage

`default_nettype wire

### rtl/binary_to_decimal_ascii.sv
// Flow: an accepted value is loaded, runs the 64-step bit-serial double dabble
// loop and a count step, then its digits follow one per cycle while the
// output side takes them. A value yields N = 1 to 20 digits; no new value is
// taken until the last digit of the current one is in the output register.
// Reset: rst_n clears the sequencer and output valid; the block is then idle.
// ============================================================================
// binary_to_decimal_ascii
// Converts an unsigned binary value into its decimal ASCII digits, most
// significant first, with leading zeros suppressed.
// ============================================================================
`default_nettype none

module binary_to_decimal_ascii (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // tdata: [63:0] value
    input  wire logic [bdasc_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // tdata: [5:0] digit_char, [10:6] digit_count, [15:11] zero
    output logic [bdasc_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,
    // tlast: last_digit
    output logic                                    m_axis_tlast
);

    bdasc_pkg::bdasc_cmd_t          cmd;
    bdasc_pkg::bdasc_status_t       status;
    logic [bdasc_pkg::CHAR_W-1:0]   out_char;
    logic [bdasc_pkg::COUNT_W-1:0]  out_count;

    // Sequencer.
    bdasc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Conversion datapath and output register.
    bdasc_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_value  (s_axis_tdata),
        .out_char  (out_char),
        .out_count (out_count),
        .out_last  (m_axis_tlast),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready)
    );

    // Pack the output item.
    assign m_axis_tdata = {
        {(bdasc_pkg::OUT_TDATA_W - bdasc_pkg::COUNT_W - bdasc_pkg::CHAR_W){1'b0}},
        out_count,
        out_char
    };

endmodule

`default_nettype wire

### rtl/bdasc_dpath.sv
// ============================================================================
// bdasc_dpath
// Double dabble shift register, BCD digit register, digit counter and the
// output register that presents one ASCII digit per item.
// ============================================================================
`default_nettype none

module bdasc_dpath (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire bdasc_pkg::bdasc_cmd_t             cmd,
    output bdasc_pkg::bdasc_status_t               status,
    input  wire logic [bdasc_pkg::IN_TDATA_W-1:0]  in_value,
    output logic [bdasc_pkg::CHAR_W-1:0]           out_char,
    output logic [bdasc_pkg::COUNT_W-1:0]          out_count,
    output logic                                   out_last,
    output logic                                   out_valid,
    input  wire logic                              out_ready
);

    logic [bdasc_pkg::VALUE_WIDTH-1:0] shift_reg, shift_next;
    logic [bdasc_pkg::BCD_W-1:0]       bcd_reg  [bdasc_pkg::MAX_DIGITS];
    logic [bdasc_pkg::BCD_W-1:0]       bcd_next [bdasc_pkg::MAX_DIGITS];
    logic [bdasc_pkg::BCD_W-1:0]       bcd_corr [bdasc_pkg::MAX_DIGITS];
    logic [bdasc_pkg::BIT_CNT_W-1:0]   bit_cnt_reg, bit_cnt_next;
    logic [bdasc_pkg::COUNT_W-1:0]     count_reg, count_next;
    logic [bdasc_pkg::COUNT_W-1:0]     found;
    logic [bdasc_pkg::DIGIT_IDX_W-1:0] pos_reg, pos_next;
    logic [bdasc_pkg::CHAR_W-1:0]      char_reg, char_next;
    logic [bdasc_pkg::COUNT_W-1:0]     ocount_reg, ocount_next;
    logic                              last_reg, last_next;
    logic                              valid_reg, valid_next;

    // Add three to every digit of five or more before the shift.
    always_comb
    begin
        for (int k = 0; k < bdasc_pkg::MAX_DIGITS; k++)
        begin
            if (bcd_reg[k] >= 4'd5)
                bcd_corr[k] = bcd_reg[k] + 4'd3;
            else
                bcd_corr[k] = bcd_reg[k];
        end
    end

    // Number of significant digits: position of the highest nonzero digit.
    always_comb
    begin
        found = bdasc_pkg::COUNT_W'(1);
        for (int k = 1; k < bdasc_pkg::MAX_DIGITS; k++)
        begin
            if (bcd_reg[k] != 4'd0)
                found = bdasc_pkg::COUNT_W'(k + 1);
        end
    end

    // Next-state logic of the datapath registers.
    always_comb
    begin
        shift_next   = shift_reg;
        bcd_next     = bcd_reg;
        bit_cnt_next = bit_cnt_reg;
        count_next   = count_reg;
        pos_next     = pos_reg;
        char_next    = char_reg;
        ocount_next  = ocount_reg;
        last_next    = last_reg;
        valid_next   = valid_reg & ~out_ready;

        if (cmd.load)
        begin
            shift_next   = in_value[bdasc_pkg::VALUE_WIDTH-1:0];
            bit_cnt_next = '0;
            for (int k = 0; k < bdasc_pkg::MAX_DIGITS; k++)
                bcd_next[k] = '0;
        end
        else if (cmd.shift)
        begin
            shift_next   = {shift_reg[bdasc_pkg::VALUE_WIDTH-2:0], 1'b0};
            bit_cnt_next = bit_cnt_reg + 1'b1;
            bcd_next[0]  = {bcd_corr[0][2:0], shift_reg[bdasc_pkg::VALUE_WIDTH-1]};
            for (int k = 1; k < bdasc_pkg::MAX_DIGITS; k++)
                bcd_next[k] = {bcd_corr[k][2:0], bcd_corr[k-1][3]};
        end
        else if (cmd.count)
        begin
            count_next = found;
            pos_next   = bdasc_pkg::DIGIT_IDX_W'(found - 1'b1);
        end

        // Load the next digit, most significant first.
        if (cmd.emit)
        begin
            char_next   = bdasc_pkg::ASCII_ZERO + {2'b00, bcd_reg[pos_reg]};
            ocount_next = count_reg;
            last_next   = (pos_reg == '0);
            valid_next  = 1'b1;
            if (pos_reg != '0)
                pos_next = pos_reg - 1'b1;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        shift_reg  <= shift_next;
        bcd_reg    <= bcd_next;
        count_reg  <= count_next;
        pos_reg    <= pos_next;
        char_reg   <= char_next;
        ocount_reg <= ocount_next;
        last_reg   <= last_next;
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_cnt_reg <= '0;
            valid_reg   <= 1'b0;
        end
        else
        begin
            bit_cnt_reg <= bit_cnt_next;
            valid_reg   <= valid_next;
        end
    end

    assign status.bit_last = (bit_cnt_reg == bdasc_pkg::BIT_CNT_W'(bdasc_pkg::VALUE_WIDTH - 1));
    assign status.pos_zero = (pos_reg == '0);
    assign status.out_free = ~valid_reg | out_ready;

    assign out_char  = char_reg;
    assign out_count = ocount_reg;
    assign out_last  = last_reg;
    assign out_valid = valid_reg;

endmodule

`default_nettype wire

### rtl/bdasc_ctrl.sv
// ============================================================================
// bdasc_ctrl
// Sequencer for load, bit-serial conversion, digit count and digit output.
// ============================================================================
`default_nettype none

module bdasc_ctrl (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire bdasc_pkg::bdasc_status_t  status,
    output bdasc_pkg::bdasc_cmd_t          cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_COUNT,
        ST_EMIT
    } state_t;

    state_t state_reg, state_next;

    // Next state and command decode.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CONVERT;
                end
            end
            ST_CONVERT:
            begin
                cmd.shift = 1'b1;
                if (status.bit_last)
                    state_next = ST_COUNT;
            end
            ST_COUNT:
            begin
                cmd.count  = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (status.pos_zero)
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

### rtl/bdasc_checker.sv
// ============================================================================
// bdasc_checker
// Port-level checks of the converter's output stream over time.
// ============================================================================
`default_nettype none

`include "binary_to_decimal_ascii_defines.svh"

module bdasc_checker (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_axis_tvalid,
    input  wire logic                               s_axis_tready,
    input  wire logic [bdasc_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    input  wire logic                               m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    input  wire logic [bdasc_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    input  wire logic                               m_axis_tlast
);

    logic                               in_seen;
    logic                               out_wait;
    logic                               out_mid;
    logic                               mid_take;
    logic [bdasc_pkg::OUT_TDATA_W:0]    out_item;
    logic [bdasc_pkg::CHAR_W-1:0]       out_char;
    logic [bdasc_pkg::COUNT_W-1:0]      out_count;
    logic                               char_ok;
    logic                               count_ok;

    // Input activity is only observed; keeps every port in use.
    assign in_seen = s_axis_tvalid & s_axis_tready & (|s_axis_tdata | 1'b1);

    // Output stream conditions and fields.
    assign out_wait  = m_axis_tvalid && !m_axis_tready;
    assign out_mid   = m_axis_tvalid && !m_axis_tlast;
    assign mid_take  = m_axis_tvalid && m_axis_tready && !m_axis_tlast;
    assign out_item  = {m_axis_tlast, m_axis_tdata};
    assign out_char  = m_axis_tdata[5:0];
    assign out_count = m_axis_tdata[10:6];
    assign char_ok   = (out_char >= 6'd48) && (out_char <= 6'd57);
    assign count_ok  = (out_count >= 5'd1) && (out_count <= 5'd20);

    // A stalled output item holds.
    `BDASC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_wait, m_axis_tvalid && $stable(out_item))

    // Every item carries a decimal ASCII digit and a digit count of 1 to 20.
    `BDASC_ASSERT_SAME(a_digit_range, clk, rst_n, m_axis_tvalid, char_ok && count_ok)

    // No new value is taken while a run of digits is still unfinished.
    `BDASC_ASSERT_SAME(a_no_accept_mid_run, clk, rst_n, out_mid, !s_axis_tready && !in_seen)

    // Within a run the next digit follows at once with the same digit count.
    `BDASC_ASSERT_NEXT(a_run_count, clk, rst_n, mid_take, m_axis_tvalid && out_count == $past(out_count))

endmodule

bind binary_to_decimal_ascii bdasc_checker u_checker (.*);

`default_nettype wire
